// ===== design/hne_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hne_pkg
// shared types and constants of the hdlc nrzi bit encoder
// ----------------------------------------------------------------------------
package hne_pkg;

    // command codes carried in the input tuser
    typedef enum logic [1:0] {
        FUNC_STUFFED   = 2'd0,
        FUNC_UNSTUFFED = 2'd1,
        FUNC_FCS       = 2'd2,
        FUNC_CRC_RST   = 2'd3
    } t_func;

    localparam logic [15:0] CRC_POLY   = 16'h8408;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [7:0]  BYTE_MASK  = 8'hFF;
    localparam logic [2:0]  ONES_STUFF = 3'd5;
    localparam logic [2:0]  ONES_MAX   = 3'd6;
    localparam logic [2:0]  BIT_LAST   = 3'd7;

endpackage

// ===== design/hdlc_nrzi_bit_encoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlc_nrzi_bit_encoder_unit
// hdlc byte to nrzi line symbol encoder with bit stuffing and crc-16 fcs
// ----------------------------------------------------------------------------
// Each input item is a command: send a byte with bit stuffing, send a byte
// without stuffing (flags), send the complemented crc-16 fcs (low byte, then
// high byte, stuffed), or reset the crc. Bytes go out lsb first, one line
// symbol per output item: a 0 bit toggles the tone, a 1 bit keeps it, and
// with stuffing on a toggle flagged as stuffed follows every five 1 bits.
// The ones counter saturates at 6, so a run of five or more ones left over
// from an unstuffed byte causes no stuff symbol until a 0 clears it.
// tlast marks the final symbol of each
// command; a crc reset gives no symbols. A bit-serial sequencer shifts one
// bit (or one stuff symbol) per cycle through the output register while the
// output is not stalled; a new command is accepted only once the sequencer
// has returned to idle.
// ----------------------------------------------------------------------------
module hdlc_nrzi_bit_encoder_unit
    import hne_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // command input
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0] i_s_axis_tuser,   // [1:0] func
    // line symbol output
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [0] tone, [7:1] zero
    output logic       o_m_axis_tuser,   // [0] stuffed
    output logic       o_m_axis_tlast    // last symbol of the command
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // sequencer state
    t_state      r_state,      n_state;
    logic [15:0] r_crc,        n_crc;
    logic        r_tone,       n_tone;
    logic [2:0]  r_ones,       n_ones;
    logic [7:0]  r_shift,      n_shift;      // bits still to send, lsb next
    logic [2:0]  r_bit_cnt,    n_bit_cnt;
    logic [7:0]  r_hi_byte,    n_hi_byte;    // second fcs byte
    logic        r_second,     n_second;     // a second byte follows
    logic        r_stuff_on,   n_stuff_on;
    logic        r_stuff_pend, n_stuff_pend; // next symbol is a stuff symbol
    logic        r_final_pend, n_final_pend; // that stuff symbol ends the item

    // output register
    logic        r_out_valid,  n_out_valid;
    logic        r_out_tone,   n_out_tone;
    logic        r_out_stuff,  n_out_stuff;
    logic        r_out_last,   n_out_last;

    logic        w_in_accept;
    logic        w_advance;
    logic        w_bit;
    logic        w_fb;
    logic        w_end_byte;
    logic        w_end_item;
    logic [2:0]  w_ones_inc;
    logic        w_stuff_next;
    t_func       w_func;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_accept     = i_s_axis_tvalid && o_s_axis_tready;
    // output register free or emptied this cycle
    assign w_advance       = !r_out_valid || i_m_axis_tready;
    assign w_func          = t_func'(i_s_axis_tuser);

    assign w_bit        = r_shift[0];
    assign w_fb         = r_crc[0] ^ w_bit;
    assign w_end_byte   = (r_bit_cnt == BIT_LAST);
    assign w_end_item   = w_end_byte && !r_second;
    assign w_ones_inc   = (r_ones < ONES_MAX) ? (r_ones + 3'd1) : r_ones;
    assign w_stuff_next = w_bit && r_stuff_on && (w_ones_inc == ONES_STUFF);

    always_comb begin
        n_state      = r_state;
        n_crc        = r_crc;
        n_tone       = r_tone;
        n_ones       = r_ones;
        n_shift      = r_shift;
        n_bit_cnt    = r_bit_cnt;
        n_hi_byte    = r_hi_byte;
        n_second     = r_second;
        n_stuff_on   = r_stuff_on;
        n_stuff_pend = r_stuff_pend;
        n_final_pend = r_final_pend;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_tone   = r_out_tone;
        n_out_stuff  = r_out_stuff;
        n_out_last   = r_out_last;

        case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    n_bit_cnt    = 3'd0;
                    n_stuff_pend = 1'b0;
                    n_final_pend = 1'b0;
                    case (w_func)
                        FUNC_STUFFED: begin
                            n_shift    = i_s_axis_tdata;
                            n_second   = 1'b0;
                            n_stuff_on = 1'b1;
                            n_state    = ST_RUN;
                        end
                        FUNC_UNSTUFFED: begin
                            n_shift    = i_s_axis_tdata;
                            n_second   = 1'b0;
                            n_stuff_on = 1'b0;
                            n_state    = ST_RUN;
                        end
                        FUNC_FCS: begin
                            // both fcs bytes are latched before either is sent
                            n_shift    = r_crc[7:0] ^ BYTE_MASK;
                            n_hi_byte  = r_crc[15:8] ^ BYTE_MASK;
                            n_second   = 1'b1;
                            n_stuff_on = 1'b1;
                            n_state    = ST_RUN;
                        end
                        FUNC_CRC_RST: begin
                            n_crc = CRC_INIT;
                        end
                        default: begin
                            n_crc = CRC_INIT;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (w_advance) begin
                    n_out_valid = 1'b1;
                    if (r_stuff_pend) begin
                        // inserted toggle, not part of the crc
                        n_tone       = !r_tone;
                        n_out_tone   = !r_tone;
                        n_out_stuff  = 1'b1;
                        n_out_last   = r_final_pend;
                        n_ones       = 3'd0;
                        n_stuff_pend = 1'b0;
                        if (r_final_pend) begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_crc = {1'b0, r_crc[15:1]} ^ (w_fb ? CRC_POLY : 16'd0);
                        n_out_stuff = 1'b0;
                        if (w_bit) begin
                            n_out_tone = r_tone;
                            n_ones     = w_ones_inc;
                        end else begin
                            n_tone     = !r_tone;
                            n_out_tone = !r_tone;
                            n_ones     = 3'd0;
                        end
                        n_out_last   = w_end_item && !w_stuff_next;
                        n_stuff_pend = w_stuff_next;
                        n_final_pend = w_end_item;
                        n_shift      = {1'b0, r_shift[7:1]};
                        n_bit_cnt    = r_bit_cnt + 3'd1;
                        if (w_end_byte) begin
                            if (r_second) begin
                                n_shift  = r_hi_byte;
                                n_second = 1'b0;
                            end else if (!w_stuff_next) begin
                                n_state = ST_IDLE;
                            end
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_crc        <= CRC_INIT;
            r_tone       <= 1'b0;
            r_ones       <= 3'd0;
            r_bit_cnt    <= 3'd0;
            r_second     <= 1'b0;
            r_stuff_on   <= 1'b0;
            r_stuff_pend <= 1'b0;
            r_final_pend <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_crc        <= n_crc;
            r_tone       <= n_tone;
            r_ones       <= n_ones;
            r_bit_cnt    <= n_bit_cnt;
            r_second     <= n_second;
            r_stuff_on   <= n_stuff_on;
            r_stuff_pend <= n_stuff_pend;
            r_final_pend <= n_final_pend;
            r_out_valid  <= n_out_valid;
        end
        r_shift     <= n_shift;
        r_hi_byte   <= n_hi_byte;
        r_out_tone  <= n_out_tone;
        r_out_stuff <= n_out_stuff;
        r_out_last  <= n_out_last;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_tone};
    assign o_m_axis_tuser  = r_out_stuff;
    assign o_m_axis_tlast  = r_out_last;

endmodule
